FILE: rtl/fpmk_pkg.sv
`default_nettype none

package fpmk_pkg;

  localparam int unsigned KEY_W   = 3;
  localparam int unsigned SPEED_W = 4;
  localparam int unsigned PINS_W  = 8;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned DIGIT_W = 2;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // input word kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE  = 3'd0,
    KEY_PREV  = 3'd1,
    KEY_NEXT  = 3'd2,
    KEY_UP    = 3'd3,
    KEY_DOWN  = 3'd4,
    KEY_REV   = 3'd5,
    KEY_POWER = 3'd6
  } key_e;

  // register index 0, selected by paddr[2]
  localparam logic REG_PRESCALE = 1'b0;

  localparam logic [7:0]         PRESCALE_RESET = 8'd10;
  localparam logic [SEG_W-1:0]   SEG_DOT        = 8'h80;
  localparam logic [DIGIT_W-1:0] DIGIT_SPEED    = 2'b01;
  localparam logic [DIGIT_W-1:0] DIGIT_INDEX    = 2'b10;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [SPEED_W-1:0] val);
    logic [SEG_W-1:0] pat;
    case (val)
      4'h0:    pat = 8'h3F;
      4'h1:    pat = 8'h06;
      4'h2:    pat = 8'h5B;
      4'h3:    pat = 8'h4F;
      4'h4:    pat = 8'h66;
      4'h5:    pat = 8'h6D;
      4'h6:    pat = 8'h7D;
      4'h7:    pat = 8'h07;
      4'h8:    pat = 8'h7F;
      4'h9:    pat = 8'h6F;
      4'hA:    pat = 8'h77;
      4'hB:    pat = 8'h7C;
      4'hC:    pat = 8'h39;
      4'hD:    pat = 8'h5E;
      4'hE:    pat = 8'h79;
      default: pat = 8'h71;
    endcase
    return pat;
  endfunction

  // power-up speeds repeat every four channels
  function automatic logic [SPEED_W-1:0] default_speed(input logic [1:0] ch);
    logic [SPEED_W-1:0] spd;
    case (ch)
      2'd0:    spd = 4'd6;
      2'd1:    spd = 4'd3;
      2'd2:    spd = 4'd5;
      default: spd = 4'd7;
    endcase
    return spd;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fpmk_in_if.sv
`default_nettype none

interface fpmk_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [fpmk_pkg::KEY_W-1:0]     key_code;

  modport source (output valid, kind, key_code, input ready);
  modport sink   (input valid, kind, key_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/fpmk_out_if.sv
`default_nettype none

interface fpmk_out_if;
  logic                           valid;
  logic                           ready;
  logic [fpmk_pkg::PINS_W-1:0]    motor_pins;
  logic [fpmk_pkg::SEG_W-1:0]     segments;
  logic [fpmk_pkg::DIGIT_W-1:0]   digit_enable;
  logic                           enabled;

  modport source (output valid, motor_pins, segments, digit_enable, enabled, input ready);
  modport sink   (input valid, motor_pins, segments, digit_enable, enabled, output ready);
endinterface

`default_nettype wire

FILE: rtl/four_channel_pwm_motor_keypad_ctrl.sv
// Multichannel PWM H-bridge controller with key commands and a two-digit display.
// Input channel (in_i): one word per timer tick (kind 0) or decoded key (kind 1).
// Output channel (out_o): one word per input word, holding the motor pins, the
// segment pattern, the digit enables and the power flag after the update.
// The prescale limit is written over the APB port at address 0 and read back there.
// The result is registered and valid in the cycle after the input word is accepted;
// all state updates happen at that accept edge.
// Throughput: one word per cycle. The result register is the only stage, and a
// new word is taken in the same cycle that the pending result is taken.
// When the receiver stalls, the result holds and in_i.ready drops until it is taken.
// Reset: power on, prescaler and slice at 0, speeds 6,3,5,7 (clamped to the top
// step), no reverse, channel 0 selected, all motor pins, segments and digit
// enables high, no result pending.
`default_nettype none

module four_channel_pwm_motor_keypad_ctrl #(
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned SPEED_STEPS = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fpmk_in_if.sink                              in_i,
  fpmk_out_if.source                           out_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fpmk_pkg::APB_AW-1:0]     paddr,
  input  wire logic [fpmk_pkg::APB_DW-1:0]     pwdata,
  output logic      [fpmk_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready
);

  localparam int unsigned SEL_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PIN_CH = (CHANNELS < 4) ? CHANNELS : 4;
  localparam logic [fpmk_pkg::SPEED_W-1:0] MAX_SPEED = fpmk_pkg::SPEED_W'(SPEED_STEPS - 1);
  localparam logic [SEL_W-1:0] LAST_CH = SEL_W'(CHANNELS - 1);

  logic [7:0]                     limit_q;
  logic [7:0]                     prescaler_q, prescaler_d;
  logic [fpmk_pkg::SPEED_W-1:0]   slice_q, slice_d;
  logic [fpmk_pkg::SPEED_W-1:0]   speed_q [CHANNELS];
  logic [fpmk_pkg::SPEED_W-1:0]   speed_d [CHANNELS];
  logic [CHANNELS-1:0]            rev_q, rev_d;
  logic [SEL_W-1:0]               sel_q, sel_d;
  logic                           power_q, power_d;
  logic                           phase_q, phase_d;
  logic [fpmk_pkg::PINS_W-1:0]    pins_q, pins_d;
  logic [fpmk_pkg::SEG_W-1:0]     seg_q, seg_d;
  logic [fpmk_pkg::DIGIT_W-1:0]   digit_q, digit_d;
  logic                           out_valid_q;

  logic                           in_acc;
  logic                           cfg_wr;
  logic [7:0]                     pre_inc;
  logic [fpmk_pkg::SPEED_W-1:0]   sel_speed;
  logic                           drive;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_acc     = in_i.valid & in_i.ready;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == fpmk_pkg::REG_PRESCALE);
  assign prdata = (paddr[2] == fpmk_pkg::REG_PRESCALE) ?
                  fpmk_pkg::APB_DW'(limit_q) : '0;

  assign pre_inc   = prescaler_q + 8'd1;
  assign sel_speed = speed_q[sel_q];

  always_comb begin
    prescaler_d = prescaler_q;
    slice_d     = slice_q;
    speed_d     = speed_q;
    rev_d       = rev_q;
    sel_d       = sel_q;
    power_d     = power_q;
    phase_d     = phase_q;
    pins_d      = pins_q;
    seg_d       = seg_q;
    digit_d     = digit_q;
    drive       = 1'b0;
    if (in_acc) begin
      if (in_i.kind == fpmk_pkg::KIND_TICK) begin
        if (power_q) begin
          if (pre_inc >= limit_q) begin
            prescaler_d = '0;
            slice_d     = (slice_q >= MAX_SPEED) ? '0 : slice_q + 4'd1;
            for (int n = 0; n < PIN_CH; n++) begin
              drive           = (slice_d >= speed_q[n]) ^ rev_q[n];
              pins_d[2*n]     = drive;
              pins_d[2*n + 1] = ~drive;
            end
          end else begin
            prescaler_d = pre_inc;
          end
          // alternate speed digit and channel index digit
          if (!phase_q) begin
            digit_d = fpmk_pkg::DIGIT_SPEED;
            seg_d   = fpmk_pkg::seg_pattern(sel_speed) |
                      (rev_q[sel_q] ? fpmk_pkg::SEG_DOT : '0);
            phase_d = 1'b1;
          end else begin
            digit_d = fpmk_pkg::DIGIT_INDEX;
            seg_d   = fpmk_pkg::seg_pattern(fpmk_pkg::SPEED_W'(sel_q));
            phase_d = 1'b0;
          end
        end
      end else begin
        unique case (in_i.key_code)
          fpmk_pkg::KEY_PREV: begin
            sel_d = (sel_q == '0) ? LAST_CH : sel_q - SEL_W'(1);
          end
          fpmk_pkg::KEY_NEXT: begin
            sel_d = (sel_q >= LAST_CH) ? '0 : sel_q + SEL_W'(1);
          end
          fpmk_pkg::KEY_UP: begin
            if (sel_speed < MAX_SPEED) speed_d[sel_q] = sel_speed + 4'd1;
          end
          fpmk_pkg::KEY_DOWN: begin
            if (sel_speed != '0) speed_d[sel_q] = sel_speed - 4'd1;
          end
          fpmk_pkg::KEY_REV: begin
            rev_d[sel_q] = ~rev_q[sel_q];
          end
          fpmk_pkg::KEY_POWER: begin
            power_d = ~power_q;
            pins_d  = '1;
            seg_d   = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= fpmk_pkg::PRESCALE_RESET;
      prescaler_q <= '0;
      slice_q     <= '0;
      for (int n = 0; n < CHANNELS; n++) begin
        speed_q[n] <= (fpmk_pkg::default_speed(2'(n)) > MAX_SPEED) ?
                      MAX_SPEED : fpmk_pkg::default_speed(2'(n));
      end
      rev_q       <= '0;
      sel_q       <= '0;
      power_q     <= 1'b1;
      phase_q     <= 1'b0;
      pins_q      <= '1;
      seg_q       <= '1;
      digit_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) limit_q <= pwdata[7:0];
      prescaler_q <= prescaler_d;
      slice_q     <= slice_d;
      speed_q     <= speed_d;
      rev_q       <= rev_d;
      sel_q       <= sel_d;
      power_q     <= power_d;
      phase_q     <= phase_d;
      pins_q      <= pins_d;
      seg_q       <= seg_d;
      digit_q     <= digit_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.motor_pins   = pins_q;
  assign out_o.segments     = seg_q;
  assign out_o.digit_enable = digit_q;
  assign out_o.enabled      = power_q;

  a_power_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.kind == fpmk_pkg::KIND_KEY && in_i.key_code == fpmk_pkg::KEY_POWER)
    |=> (power_q != $past(power_q)))
    else $error("power flag did not toggle on power key");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.kind == fpmk_pkg::KIND_TICK && !power_q)
    |=> ($stable(slice_q) && $stable(prescaler_q) && $stable(seg_q)))
    else $error("tick while off changed state");

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q <= LAST_CH)
    else $error("selected channel out of range");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_speed <= MAX_SPEED) && (slice_q <= MAX_SPEED))
    else $error("speed or slice beyond top step");

endmodule

`default_nettype wire

FILE: test/four_channel_pwm_motor_keypad_ctrl_tb.sv
`timescale 1ns / 100ps

module four_channel_pwm_motor_keypad_ctrl_tb;

  localparam int unsigned NCH         = 4;
  localparam logic [fpmk_pkg::SPEED_W-1:0] TOP_SPEED = 4'd9;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam logic [fpmk_pkg::APB_AW-1:0] PRESCALE_ADDR = {fpmk_pkg::REG_PRESCALE, 2'b00};

  typedef struct packed {
    logic [fpmk_pkg::PINS_W-1:0]  pins;
    logic [fpmk_pkg::SEG_W-1:0]   seg;
    logic [fpmk_pkg::DIGIT_W-1:0] digit;
    logic                         on;
  } panel_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [fpmk_pkg::APB_AW-1:0] paddr;
  logic [fpmk_pkg::APB_DW-1:0] pwdata;
  logic [fpmk_pkg::APB_DW-1:0] prdata;
  logic pready;

  fpmk_in_if  in_ch ();
  fpmk_out_if out_ch ();

  four_channel_pwm_motor_keypad_ctrl DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // predicted controller state
  logic [7:0]                   ctl_limit, ctl_presc;
  logic [fpmk_pkg::SPEED_W-1:0] ctl_slice;
  logic [fpmk_pkg::SPEED_W-1:0] ctl_speed [NCH];
  logic                         ctl_rev [NCH];
  logic [1:0]                   ctl_sel;
  logic                         ctl_on, ctl_phase;
  logic [fpmk_pkg::PINS_W-1:0]  ctl_pins;
  logic [fpmk_pkg::SEG_W-1:0]   ctl_seg;
  logic [fpmk_pkg::DIGIT_W-1:0] ctl_digit;

  panel_t      pin_seg_queue [$];
  panel_t      seen_word, want_word;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          gaps_on;
  bit          hold_req;

  function automatic logic [fpmk_pkg::SEG_W-1:0] digit_glyph(input logic [3:0] v);
    logic [fpmk_pkg::SEG_W-1:0] g;
    case (v)
      4'd0:    g = 8'd63;
      4'd1:    g = 8'd6;
      4'd2:    g = 8'd91;
      4'd3:    g = 8'd79;
      4'd4:    g = 8'd102;
      4'd5:    g = 8'd109;
      4'd6:    g = 8'd125;
      4'd7:    g = 8'd7;
      4'd8:    g = 8'd127;
      4'd9:    g = 8'd111;
      4'd10:   g = 8'h77;
      4'd11:   g = 8'h7C;
      4'd12:   g = 8'h39;
      4'd13:   g = 8'h5E;
      4'd14:   g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

  function automatic void reset_controller_model();
    ctl_limit    = fpmk_pkg::PRESCALE_RESET;
    ctl_presc    = '0;
    ctl_slice    = '0;
    ctl_speed[0] = 4'd6;
    ctl_speed[1] = 4'd3;
    ctl_speed[2] = 4'd5;
    ctl_speed[3] = 4'd7;
    for (int n = 0; n < NCH; n++) ctl_rev[n] = 1'b0;
    ctl_sel   = '0;
    ctl_on    = 1'b1;
    ctl_phase = 1'b0;
    ctl_pins  = '1;
    ctl_seg   = '1;
    ctl_digit = '1;
  endfunction

  function automatic panel_t controller_step(input logic kind,
                                             input logic [fpmk_pkg::KEY_W-1:0] code);
    logic drive;
    int   n;
    if (kind == fpmk_pkg::KIND_TICK) begin
      if (ctl_on) begin
        ctl_presc = ctl_presc + 8'd1;
        // a lowered limit below the count still trips here
        if (ctl_presc >= ctl_limit) begin
          ctl_presc = '0;
          ctl_slice = (ctl_slice >= TOP_SPEED) ? '0 : ctl_slice + 4'd1;
          for (n = 0; n < NCH; n++) begin
            drive = (ctl_slice >= ctl_speed[n]) ^ ctl_rev[n];
            ctl_pins[2*n]   = drive;
            ctl_pins[2*n+1] = ~drive;
          end
        end
        if (!ctl_phase) begin
          ctl_digit = fpmk_pkg::DIGIT_SPEED;
          ctl_seg   = digit_glyph(ctl_speed[ctl_sel]) |
                      (ctl_rev[ctl_sel] ? fpmk_pkg::SEG_DOT : '0);
          ctl_phase = 1'b1;
        end else begin
          ctl_digit = fpmk_pkg::DIGIT_INDEX;
          ctl_seg   = digit_glyph({2'b00, ctl_sel});
          ctl_phase = 1'b0;
        end
      end
    end else begin
      case (code)
        fpmk_pkg::KEY_PREV: ctl_sel = ctl_sel - 2'd1;
        fpmk_pkg::KEY_NEXT: ctl_sel = ctl_sel + 2'd1;
        fpmk_pkg::KEY_UP: begin
          if (ctl_speed[ctl_sel] < TOP_SPEED) ctl_speed[ctl_sel] = ctl_speed[ctl_sel] + 4'd1;
        end
        fpmk_pkg::KEY_DOWN: begin
          if (ctl_speed[ctl_sel] != 0) ctl_speed[ctl_sel] = ctl_speed[ctl_sel] - 4'd1;
        end
        fpmk_pkg::KEY_REV: ctl_rev[ctl_sel] = ~ctl_rev[ctl_sel];
        fpmk_pkg::KEY_POWER: begin
          ctl_on   = ~ctl_on;
          ctl_pins = '1;
          ctl_seg  = '0;
        end
        default: ;
      endcase
    end
    return {ctl_pins, ctl_seg, ctl_digit, ctl_on};
  endfunction

  task automatic send_word(input logic kind, input logic [fpmk_pkg::KEY_W-1:0] code);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.key_code <= code;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pin_seg_queue.push_back(controller_step(kind, code));
  endtask

  task automatic send_random(input int unsigned tick_pct);
    logic [fpmk_pkg::KEY_W-1:0] code;
    code = fpmk_pkg::KEY_W'($urandom_range(0, 6));
    // keep the controller on most of the time so ticks do real work
    if (!ctl_on && $urandom_range(0, 3) == 0)
      send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_POWER);
    else if ($urandom_range(0, 99) < tick_pct)
      send_word(fpmk_pkg::KIND_TICK, code);
    else if ($urandom_range(0, 24) == 0)
      send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_POWER);
    else begin
      code = fpmk_pkg::KEY_W'($urandom_range(0, 5));
      send_word(fpmk_pkg::KIND_KEY, code);
    end
  endtask

  task automatic set_prescale(input logic [7:0] value);
    in_ch.valid <= 1'b0;
    while (pin_seg_queue.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PRESCALE_ADDR;
    pwdata  <= {{(fpmk_pkg::APB_DW-8){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    ctl_limit = value;
    // read it back; psel stays up into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[7:0] !== value) begin
      if (fail_count < REPORT_MAX)
        $display("%0t prescale readback: expected %0d, got %0d", $time, value, prdata[7:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_traffic(input int unsigned words, input int unsigned tick_pct);
    repeat (words) send_random(tick_pct);
  endtask

  task automatic test_display_and_keys();
    send_word(fpmk_pkg::KIND_TICK, fpmk_pkg::KEY_NONE);
    send_word(fpmk_pkg::KIND_TICK, fpmk_pkg::KEY_POWER);  // code ignored on a tick
    send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_NONE);
    send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_PREV);    // 0 wraps to 3
    repeat (3) send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_UP);  // held at the top speed
    send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_REV);
    send_word(fpmk_pkg::KIND_TICK, fpmk_pkg::KEY_NONE);
    send_word(fpmk_pkg::KIND_TICK, fpmk_pkg::KEY_NONE);
    send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_NEXT);    // 3 wraps to 0
    send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_NEXT);
    repeat (4) send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_DOWN);  // held at zero
    send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_POWER);
    send_word(fpmk_pkg::KIND_TICK, fpmk_pkg::KEY_NONE);   // no effect while off
    send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_UP);      // keys still act while off
    send_word(fpmk_pkg::KIND_KEY, fpmk_pkg::KEY_POWER);
    send_word(fpmk_pkg::KIND_TICK, fpmk_pkg::KEY_NONE);
  endtask

  task automatic test_fast_prescale();
    set_prescale(8'd1);
    run_traffic(80, 75);
  endtask

  task automatic test_slow_prescale();
    set_prescale(8'd255);
    run_traffic(330, 95);
  endtask

  task automatic test_backpressure();
    // limit drops below the running count
    set_prescale(8'd2);
    hold_req = 1'b1;
    run_traffic(60, 70);
  endtask

  task automatic test_zero_limit();
    set_prescale(8'd0);
    run_traffic(60, 70);
  endtask

  task automatic test_random_limit();
    set_prescale(8'($urandom_range(1, 254)));
    run_traffic(60, 70);
  endtask

  task automatic test_steady_stream();
    set_prescale(fpmk_pkg::PRESCALE_RESET);
    gaps_on = 1'b0;
    run_traffic(60, 70);
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni)
        out_ch.ready <= 1'b0;
      else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else
        out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen_word = {out_ch.motor_pins, out_ch.segments, out_ch.digit_enable, out_ch.enabled};
      if (pin_seg_queue.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("%0t unexpected word: pins %h seg %h digits %b on %b", $time,
                   seen_word.pins, seen_word.seg, seen_word.digit, seen_word.on);
        fail_count++;
      end else begin
        want_word = pin_seg_queue.pop_front();
        if (seen_word !== want_word) begin
          if (fail_count < REPORT_MAX)
            $display({"%0t word mismatch: expected pins %h seg %h digits %b on %b, ",
                      "got pins %h seg %h digits %b on %b"},
                     $time, want_word.pins, want_word.seg, want_word.digit, want_word.on,
                     seen_word.pins, seen_word.seg, seen_word.digit, seen_word.on);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("four_channel_pwm_motor_keypad_ctrl_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = fpmk_pkg::KIND_TICK;
    in_ch.key_code = fpmk_pkg::KEY_NONE;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    gaps_on        = 1'b1;
    hold_req       = 1'b0;
    fail_count     = 0;
    quiet_cycles   = 0;
    reset_controller_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_display_and_keys();
    test_fast_prescale();
    test_slow_prescale();
    test_backpressure();
    test_zero_limit();
    test_random_limit();
    test_steady_stream();

    in_ch.valid <= 1'b0;
    while (pin_seg_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pin_seg_queue.size() != 0) fail_count++;
    if (fail_count == 0)
      $display("four_channel_pwm_motor_keypad_ctrl_tb: done, clean");
    else
      $display("four_channel_pwm_motor_keypad_ctrl_tb: done, errors");
    $finish;
  end

endmodule
